// ----- hw/rtl/slc_pkg.sv -----
// ----------------------------------------------------------------------------
// slc_pkg: shared types and constants for the spectrum level to colour block
// Register map, configuration struct, back-end state type and span helper.
// ----------------------------------------------------------------------------
package slc_pkg;

  localparam int unsigned MAX_BINS    = 64;
  localparam int unsigned LEVEL_BITS  = 16;
  localparam int unsigned CUT_W       = 16;
  localparam int unsigned COL_W       = 8;
  localparam int unsigned GAMMA_SHIFT = 8;
  localparam int unsigned NUM_CH      = 3;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned CFG_ADDR_W  = 4;
  localparam int unsigned CFG_DATA_W  = 16;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_LOW_CUT    = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_HIGH_CUT   = 4'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_FROM_RED   = 4'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_FROM_GREEN = 4'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_FROM_BLUE  = 4'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_TO_RED     = 4'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_TO_GREEN   = 4'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_TO_BLUE    = 4'd7;

  // colour channel positions in the packed colour arrays
  localparam int unsigned CH_RED   = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_BLUE  = 2;

  typedef struct packed {
    logic [CUT_W-1:0]             low_cut;
    logic [CUT_W-1:0]             high_cut;
    logic [NUM_CH-1:0][COL_W-1:0] from_col;
    logic [NUM_CH-1:0][COL_W-1:0] to_col;
  } cfg_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MULD,
    BK_PROD,
    BK_SUM,
    BK_DIV,
    BK_SQ,
    BK_OUT
  } back_state_e;

  // width of the clipping band, zero when the band is empty
  function automatic logic [CUT_W-1:0] span_of(cfg_t c);
    return (c.high_cut > c.low_cut) ? (c.high_cut - c.low_cut) : '0;
  endfunction

endpackage

// ----- hw/rtl/slc_if.sv -----
// ----------------------------------------------------------------------------
// slc_if: channel interfaces of the spectrum level to colour block
// Bin input channel, colour output channel and register write channel.
// ----------------------------------------------------------------------------
interface slc_in_if #(
  parameter int unsigned LevelBits = slc_pkg::LEVEL_BITS
);
  logic                 valid;
  logic                 ready;
  logic [LevelBits-1:0] level;
  logic                 last;

  modport source (output valid, level, last, input ready);
  modport sink   (input valid, level, last, output ready);
endinterface

interface slc_out_if;
  logic                         valid;
  logic                         ready;
  logic [slc_pkg::COL_W-1:0]    red;
  logic [slc_pkg::COL_W-1:0]    green;
  logic [slc_pkg::COL_W-1:0]    blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface slc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [slc_pkg::CFG_ADDR_W-1:0] addr;
  logic [slc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

// ----- hw/rtl/slc_queue.sv -----
// ----------------------------------------------------------------------------
// slc_queue: small register FIFO between front and back end
// Holds finished group totals until the back end is free to take them.
// ----------------------------------------------------------------------------
module slc_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = slc_pkg::QUEUE_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [Width-1:0]           wdata_i,
  output logic                       ready_o,
  input  logic                       pop_i,
  output logic [Width-1:0]           rdata_o,
  output logic                       valid_o,
  output logic [$clog2(Depth+1)-1:0] level_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned LvlW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [LvlW-1:0]  lvl_q, lvl_d;
  logic             do_push, do_pop;

  assign ready_o = (lvl_q != LvlW'(Depth));
  assign valid_o = (lvl_q != '0);
  assign rdata_o = mem_q[rptr_q];
  assign level_o = lvl_q;

  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    lvl_d  = lvl_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      lvl_d = lvl_q + 1'b1;
    end else if (do_pop && !do_push) begin
      lvl_d = lvl_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      lvl_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      lvl_q  <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ----- hw/rtl/slc_front.sv -----
// ----------------------------------------------------------------------------
// slc_front: bin accumulator
// Clips each level to the cut band, sums contributions and counts bins;
// pushes the group totals to the queue on the last bin.
// ----------------------------------------------------------------------------
module slc_front #(
  parameter int unsigned MaxBins   = slc_pkg::MAX_BINS,
  parameter int unsigned LevelBits = slc_pkg::LEVEL_BITS,
  parameter int unsigned SumW      = LevelBits + $clog2(MaxBins),
  parameter int unsigned CntW      = $clog2(MaxBins + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  slc_pkg::cfg_t        cfg_i,
  input  logic                 in_valid_i,
  input  logic [LevelBits-1:0] in_level_i,
  input  logic                 in_last_i,
  output logic                 in_ready_o,
  output logic                 push_o,
  output logic [SumW-1:0]      push_sum_o,
  output logic [CntW-1:0]      push_cnt_o,
  input  logic                 push_ready_i
);

  localparam int unsigned CmpW =
    (LevelBits > slc_pkg::CUT_W) ? LevelBits : slc_pkg::CUT_W;

  logic [SumW-1:0]          sum_q, sum_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [slc_pkg::CUT_W-1:0] span;
  logic [CmpW-1:0]          lvl_x, low_x, high_x, diff;
  logic [LevelBits-1:0]     contrib;
  logic                     room, accept;

  assign span   = slc_pkg::span_of(cfg_i);
  assign lvl_x  = CmpW'(in_level_i);
  assign low_x  = CmpW'(cfg_i.low_cut);
  assign high_x = CmpW'(cfg_i.high_cut);
  // contribution never exceeds the level itself, so it fits the level width
  assign diff   = (lvl_x < high_x) ? (lvl_x - low_x) : CmpW'(span);

  always_comb begin
    contrib = '0;
    if ((span != '0) && (lvl_x > low_x)) begin
      contrib = diff[LevelBits-1:0];
    end
  end

  assign room   = (cnt_q < CntW'(MaxBins));
  assign sum_d  = room ? (sum_q + SumW'(contrib)) : sum_q;
  assign cnt_d  = room ? (cnt_q + 1'b1) : cnt_q;
  assign accept = in_valid_i && push_ready_i;

  assign in_ready_o = push_ready_i;
  assign push_o     = accept && in_last_i;
  assign push_sum_o = sum_d;
  assign push_cnt_o = cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else if (accept) begin
      if (in_last_i) begin
        sum_q <= '0;
        cnt_q <= '0;
      end else begin
        sum_q <= sum_d;
        cnt_q <= cnt_d;
      end
    end
  end

endmodule

// ----- hw/rtl/slc_back.sv -----
// ----------------------------------------------------------------------------
// slc_back: colour blend, divide and gamma square
// Takes group totals from the queue, works the three channels in turn
// through one restoring divider and holds the colour in an output register.
// ----------------------------------------------------------------------------
module slc_back #(
  parameter int unsigned SumW = 22,
  parameter int unsigned CntW = 7
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  slc_pkg::cfg_t              cfg_i,
  input  logic                       q_valid_i,
  input  logic [SumW-1:0]            q_sum_i,
  input  logic [CntW-1:0]            q_cnt_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [slc_pkg::COL_W-1:0]  out_red_o,
  output logic [slc_pkg::COL_W-1:0]  out_green_o,
  output logic [slc_pkg::COL_W-1:0]  out_blue_o
);

  localparam int unsigned ColW = slc_pkg::COL_W;
  localparam int unsigned DW   = CntW + slc_pkg::CUT_W;
  localparam int unsigned NumW = DW + ColW;
  localparam int unsigned MW   = (SumW > DW) ? SumW : DW;
  localparam int unsigned SqW  = 2 * ColW;
  localparam logic [$clog2(ColW)-1:0] LastBit = $clog2(ColW)'(ColW - 1);
  localparam logic [1:0]              LastCh  = 2'(slc_pkg::NUM_CH - 1);

  slc_pkg::back_state_e state_q, state_d;

  logic [DW-1:0]      s_q, s_d, d_q, d_d, rem_q, rem_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [1:0]         ch_q, ch_d;
  logic [NumW-1:0]    pa_q, pa_d, pb_q, pb_d;
  logic [ColW-1:0]    nlo_q, nlo_d, quo_q, quo_d;
  logic [$clog2(ColW)-1:0] bit_q, bit_d;
  logic [slc_pkg::NUM_CH-1:0][ColW-1:0] res_q, res_d;
  logic [slc_pkg::NUM_CH-1:0][ColW-1:0] out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic [MW-1:0]      s_wide;
  logic [DW-1:0]      cnt_x, span_x;
  logic [NumW-1:0]    from_x, to_x, dms_x, s_x, num;
  logic [DW:0]        trial;
  logic               fits;
  logic [SqW-1:0]     sq, sq_sh;

  assign s_wide = MW'(q_sum_i);
  assign cnt_x  = DW'(cnt_q);
  assign span_x = DW'(slc_pkg::span_of(cfg_i));
  assign from_x = NumW'(cfg_i.from_col[ch_q]);
  assign to_x   = NumW'(cfg_i.to_col[ch_q]);
  assign dms_x  = NumW'(d_q - s_q);
  assign s_x    = NumW'(s_q);
  assign num    = pa_q + pb_q;
  assign trial  = {rem_q, nlo_q[ColW-1]};
  assign fits   = (trial >= {1'b0, d_q});
  assign sq     = SqW'(quo_q) * SqW'(quo_q);
  assign sq_sh  = sq >> slc_pkg::GAMMA_SHIFT;

  always_comb begin
    state_d     = state_q;
    s_d         = s_q;
    cnt_d       = cnt_q;
    d_d         = d_q;
    ch_d        = ch_q;
    pa_d        = pa_q;
    pb_d        = pb_q;
    rem_d       = rem_q;
    nlo_d       = nlo_q;
    quo_d       = quo_q;
    bit_d       = bit_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    pop_o       = 1'b0;

    case (state_q)
      slc_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          pop_o   = 1'b1;
          s_d     = s_wide[DW-1:0];  // sum never exceeds the divisor
          cnt_d   = q_cnt_i;
          state_d = slc_pkg::BK_MULD;
        end
      end
      slc_pkg::BK_MULD: begin
        d_d     = cnt_x * span_x;
        ch_d    = '0;
        state_d = slc_pkg::BK_PROD;
      end
      slc_pkg::BK_PROD: begin
        pa_d    = from_x * dms_x;
        pb_d    = to_x * s_x;
        state_d = slc_pkg::BK_SUM;
      end
      slc_pkg::BK_SUM: begin
        if (d_q == '0) begin
          quo_d   = cfg_i.from_col[ch_q];
          state_d = slc_pkg::BK_SQ;
        end else begin
          // numerator < 256 * D, so the top part already sits below D
          rem_d   = num[NumW-1:ColW];
          nlo_d   = num[ColW-1:0];
          bit_d   = '0;
          state_d = slc_pkg::BK_DIV;
        end
      end
      slc_pkg::BK_DIV: begin
        if (fits) begin
          rem_d = DW'(trial - {1'b0, d_q});
        end else begin
          rem_d = trial[DW-1:0];
        end
        quo_d = {quo_q[ColW-2:0], fits};
        nlo_d = {nlo_q[ColW-2:0], 1'b0};
        bit_d = bit_q + 1'b1;
        if (bit_q == LastBit) begin
          state_d = slc_pkg::BK_SQ;
        end
      end
      slc_pkg::BK_SQ: begin
        res_d[ch_q] = sq_sh[ColW-1:0];
        if (ch_q == LastCh) begin
          state_d = slc_pkg::BK_OUT;
        end else begin
          ch_d    = ch_q + 1'b1;
          state_d = slc_pkg::BK_PROD;
        end
      end
      slc_pkg::BK_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = slc_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = slc_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= slc_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q   <= s_d;
    cnt_q <= cnt_d;
    d_q   <= d_d;
    ch_q  <= ch_d;
    pa_q  <= pa_d;
    pb_q  <= pb_d;
    rem_q <= rem_d;
    nlo_q <= nlo_d;
    quo_q <= quo_d;
    bit_q <= bit_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = out_q[slc_pkg::CH_RED];
  assign out_green_o = out_q[slc_pkg::CH_GREEN];
  assign out_blue_o  = out_q[slc_pkg::CH_BLUE];

endmodule

// ----- hw/rtl/spectrum_level_to_color_core.sv -----
// ----------------------------------------------------------------------------
// spectrum_level_to_color_core: spectrum bin levels to one RGB colour
// Accumulates clipped bin levels per group and blends a colour pair by the
// group's fill fraction, with a squared gamma on each channel.
// ----------------------------------------------------------------------------
// Usage
//   in_i  : one bin level per word, last = 1 on the final bin of a group.
//           Taken at one word per cycle while the group queue has room.
//   out_o : one colour word per group, issued after the group's last bin.
//   cfg_i : register writes (index 0..7), always ready; indexes above 7
//           are ignored. Write only while the block is idle.
// Timing
//   The front end takes a bin every cycle while the group queue has room.
//   Each group passes the back end through these steps in order: the pop,
//   the divisor product, per channel a product, a sum, eight divide steps
//   and a square, then the load of the output register; a zero divisor
//   skips the divide. The back end finishes a group before it pops the
//   next one, so groups are worked one at a time.
// Reset and stall
//   Reset clears the running sum, the bin count, the queue and the output
//   valid, and loads the register defaults. A stalled receiver holds the
//   colour word; the back end and then the two-entry queue fill up, and
//   only then does in_i drop ready.
// ----------------------------------------------------------------------------
module spectrum_level_to_color_core #(
  parameter int unsigned MaxBins = slc_pkg::MAX_BINS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  slc_in_if.sink     in_i,
  slc_out_if.source  out_o,
  slc_cfg_if.sink    cfg_i
);

  // level width is fixed by the bin channel
  localparam int unsigned LevelBits = slc_pkg::LEVEL_BITS;
  localparam int unsigned SumW  = LevelBits + $clog2(MaxBins);
  localparam int unsigned CntW  = $clog2(MaxBins + 1);
  localparam int unsigned QW    = SumW + CntW;
  localparam int unsigned Depth = slc_pkg::QUEUE_DEPTH;
  localparam int unsigned LvlW  = $clog2(Depth + 1);
  localparam int unsigned CutW  = slc_pkg::CUT_W;
  localparam int unsigned ColW  = slc_pkg::COL_W;

  // --------------------------------------------------------------------------
  // Register file: written whenever the write channel fires
  // --------------------------------------------------------------------------
  slc_pkg::cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_cut                    <= '0;
      cfg_q.high_cut                   <= CutW'(255);
      cfg_q.from_col                   <= '0;
      cfg_q.to_col                     <= '1;
    end else if (cfg_i.valid) begin
      case (cfg_i.addr)
        slc_pkg::REG_LOW_CUT:    cfg_q.low_cut  <= cfg_i.data[CutW-1:0];
        slc_pkg::REG_HIGH_CUT:   cfg_q.high_cut <= cfg_i.data[CutW-1:0];
        slc_pkg::REG_FROM_RED:   begin
          cfg_q.from_col[slc_pkg::CH_RED] <= cfg_i.data[ColW-1:0];
        end
        slc_pkg::REG_FROM_GREEN: begin
          cfg_q.from_col[slc_pkg::CH_GREEN] <= cfg_i.data[ColW-1:0];
        end
        slc_pkg::REG_FROM_BLUE:  begin
          cfg_q.from_col[slc_pkg::CH_BLUE] <= cfg_i.data[ColW-1:0];
        end
        slc_pkg::REG_TO_RED:     begin
          cfg_q.to_col[slc_pkg::CH_RED] <= cfg_i.data[ColW-1:0];
        end
        slc_pkg::REG_TO_GREEN:   begin
          cfg_q.to_col[slc_pkg::CH_GREEN] <= cfg_i.data[ColW-1:0];
        end
        slc_pkg::REG_TO_BLUE:    begin
          cfg_q.to_col[slc_pkg::CH_BLUE] <= cfg_i.data[ColW-1:0];
        end
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Front end: clip and accumulate, push totals on the last bin
  // --------------------------------------------------------------------------
  logic            q_push, q_ready, q_pop, q_valid;
  logic [SumW-1:0] push_sum;
  logic [CntW-1:0] push_cnt;
  logic [QW-1:0]   q_rdata;
  logic [LvlW-1:0] q_level;

  slc_front #(
    .MaxBins   (MaxBins),
    .LevelBits (LevelBits),
    .SumW      (SumW),
    .CntW      (CntW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_i.valid),
    .in_level_i   (in_i.level),
    .in_last_i    (in_i.last),
    .in_ready_o   (in_i.ready),
    .push_o       (q_push),
    .push_sum_o   (push_sum),
    .push_cnt_o   (push_cnt),
    .push_ready_i (q_ready)
  );

  // --------------------------------------------------------------------------
  // Group queue: decouples the bin stream from the divider
  // --------------------------------------------------------------------------
  slc_queue #(
    .Width (QW),
    .Depth (Depth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i ({push_sum, push_cnt}),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .valid_o (q_valid),
    .level_o (q_level)
  );

  // --------------------------------------------------------------------------
  // Back end: blend, divide, square, output register
  // --------------------------------------------------------------------------
  slc_back #(
    .SumW (SumW),
    .CntW (CntW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_sum_i     (q_rdata[QW-1:CntW]),
    .q_cnt_i     (q_rdata[CntW-1:0]),
    .pop_o       (q_pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_red_o   (out_o.red),
    .out_green_o (out_o.green),
    .out_blue_o  (out_o.blue)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> (q_level != '0))
    else $error("back end popped an empty group queue");

  a_level_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_level <= LvlW'(Depth))
    else $error("group queue occupancy out of range");

  a_stall_only_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (q_level == LvlW'(Depth)))
    else $error("bin input stalled with room in the group queue");

  a_push_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push && q_ready && !q_pop) |=> (q_level == $past(q_level) + 1'b1))
    else $error("group pushed but queue occupancy did not grow");

endmodule

// ----- tb/tb_spectrum_level_to_color_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spectrum_level_to_color_core: self-checking bench for the colour core
// Streams bin words in groups, predicts each group's gamma-squared colour,
// and checks every colour word in order against the prediction. Registers
// are rewritten between phases while the core is idle.
// ----------------------------------------------------------------------------
module tb_spectrum_level_to_color_core;
  import slc_pkg::*;

  localparam int unsigned CLK_PERIOD      = 10;
  localparam int unsigned RESET_CYCLES    = 6;
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned DRAIN_CYCLES    = 64;
  localparam int unsigned LONG_HOLD       = 600;   // receiver hold-off for back-pressure
  localparam int unsigned RANDOM_PHASES   = 10;
  localparam int unsigned ITEMS_PER_PHASE = 175;
  localparam int unsigned PRESSURE_PHASE  = 3;

  // decoded by nothing: the core must leave every register alone
  localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED = 4'd15;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] level;
    logic                  last;
  } bin_t;

  typedef struct packed {
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
  } colour_t;

  typedef enum int unsigned {
    BAND_FULL,
    BAND_EMPTY,
    BAND_INVERTED,
    BAND_NARROW,
    BAND_WIDE
  } band_shape_e;

  logic clk;
  logic rst_n;

  slc_in_if  in_bus ();
  slc_out_if out_bus ();
  slc_cfg_if cfg_bus ();

  spectrum_level_to_color_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Shadow of the core: register copy, group accumulator, expected colours
  // --------------------------------------------------------------------------
  cfg_t              cut_cfg;
  longint unsigned   group_sum;
  longint unsigned   group_bins;
  colour_t           colour_due[$];

  bin_t              pending_bins[$];
  int unsigned       bins_launched;
  int unsigned       bins_taken;
  int unsigned       colours_taken;
  int unsigned       colours_seen;
  int unsigned       hold_asks;
  int unsigned       hold_served;
  int unsigned       errors;

  // blend from -> to by s/d, truncate to a byte, then square and keep the top byte
  function automatic logic [COL_W-1:0] gamma_blend(input logic [COL_W-1:0] from_c,
                                                   input logic [COL_W-1:0] to_c,
                                                   input longint unsigned s,
                                                   input longint unsigned d);
    longint unsigned  mix;
    logic [COL_W-1:0] c8;
    logic [15:0]      sq;
    if (d == 0) mix = from_c;
    else mix = (from_c * (d - s) + to_c * s) / d;
    c8 = mix[COL_W-1:0];
    sq = c8 * c8;
    return sq[15:GAMMA_SHIFT];
  endfunction

  // one accepted bin word; a word with last set closes the group
  function automatic void fold_bin(input bin_t b);
    logic [CUT_W-1:0] band;
    longint unsigned  divisor;
    colour_t          c;
    band = (cut_cfg.high_cut > cut_cfg.low_cut) ? cut_cfg.high_cut - cut_cfg.low_cut : '0;
    // once the group is full, further bins are dropped (last still counts)
    if (group_bins < MAX_BINS) begin
      if (band != 0 && b.level > cut_cfg.low_cut)
        group_sum += (b.level < cut_cfg.high_cut) ? b.level - cut_cfg.low_cut : band;
      group_bins++;
    end
    if (b.last) begin
      // empty band gives a zero divisor, and then the from colour
      divisor = group_bins * band;
      c.red   = gamma_blend(cut_cfg.from_col[CH_RED], cut_cfg.to_col[CH_RED],
                            group_sum, divisor);
      c.green = gamma_blend(cut_cfg.from_col[CH_GREEN], cut_cfg.to_col[CH_GREEN],
                            group_sum, divisor);
      c.blue  = gamma_blend(cut_cfg.from_col[CH_BLUE], cut_cfg.to_col[CH_BLUE],
                            group_sum, divisor);
      colour_due.insert(colour_due.size(), c);
      group_sum  = 0;
      group_bins = 0;
    end
  endfunction

  function automatic int unsigned idle_draw(input bit burst);
    return burst ? 0 : $urandom_range(0, 8);
  endfunction

  // --------------------------------------------------------------------------
  // Bin driver: words change on the falling edge
  // --------------------------------------------------------------------------
  int unsigned in_gap;
  bit          in_burst;

  always @(negedge clk) begin : bin_driver
    bin_t w;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (in_bus.valid && bins_taken != bins_launched) begin
      // word still on offer, hold it
    end else if (in_gap != 0) begin
      in_gap--;
      in_bus.valid <= 1'b0;
    end else if (pending_bins.size() != 0) begin
      w = pending_bins.pop_front();
      in_bus.valid <= 1'b1;
      in_bus.level <= w.level;
      in_bus.last  <= w.last;
      bins_launched++;
      if ($urandom_range(0, 49) == 0) in_burst = !in_burst;
      in_gap = idle_draw(in_burst);
    end else begin
      in_bus.valid <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Colour receiver: random stalls per word, plus one long hold-off on request
  // --------------------------------------------------------------------------
  int unsigned out_wait;
  int unsigned hold_left;
  bit          out_burst;

  always @(negedge clk) begin : colour_receiver
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (colours_seen != colours_taken) begin
        colours_seen = colours_taken;
        if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
        out_wait = idle_draw(out_burst);
      end
      if (hold_served != hold_asks) begin
        hold_served = hold_asks;
        hold_left   = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (out_wait != 0) begin
        out_wait--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: both handshakes sampled on the rising edge, bins folded first
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [COL_W-1:0] want,
                             input logic [COL_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    colour_t want;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        fold_bin(bin_t'{in_bus.level, in_bus.last});
        bins_taken++;
      end
      if (out_bus.valid && out_bus.ready) begin
        colours_taken++;
        if (colour_due.size() == 0) begin
          errors++;
          $display("%0t: colour word with none expected, expected none, actual %0d/%0d/%0d",
                   $time, out_bus.red, out_bus.green, out_bus.blue);
        end else begin
          want = colour_due.pop_front();
          check_field("red",   want.red,   out_bus.red);
          check_field("green", want.green, out_bus.green);
          check_field("blue",  want.blue,  out_bus.blue);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.addr  <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      REG_LOW_CUT:    cut_cfg.low_cut          = val;
      REG_HIGH_CUT:   cut_cfg.high_cut         = val;
      REG_FROM_RED:   cut_cfg.from_col[CH_RED]   = val[COL_W-1:0];
      REG_FROM_GREEN: cut_cfg.from_col[CH_GREEN] = val[COL_W-1:0];
      REG_FROM_BLUE:  cut_cfg.from_col[CH_BLUE]  = val[COL_W-1:0];
      REG_TO_RED:     cut_cfg.to_col[CH_RED]     = val[COL_W-1:0];
      REG_TO_GREEN:   cut_cfg.to_col[CH_GREEN]   = val[COL_W-1:0];
      REG_TO_BLUE:    cut_cfg.to_col[CH_BLUE]    = val[COL_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic put_bin(input logic [LEVEL_BITS-1:0] level, input logic last);
    pending_bins.insert(pending_bins.size(), bin_t'{level, last});
  endtask

  // wait for every word to go in and every colour to come out, then let it settle
  task automatic drain();
    while (pending_bins.size() != 0 || bins_taken != bins_launched ||
           colour_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // colour byte biased to the ends; the upper byte is junk the core must drop
  function automatic logic [CFG_DATA_W-1:0] colour_word();
    logic [7:0] lo;
    case ($urandom_range(0, 5))
      0:       lo = 8'h00;
      1:       lo = 8'hFF;
      default: lo = 8'($urandom_range(0, 255));
    endcase
    return {8'($urandom_range(0, 255)), lo};
  endfunction

  // levels cluster round the cut points, with the odd full-range value
  function automatic logic [LEVEL_BITS-1:0] pick_level();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return '1;
      2:       return cut_cfg.low_cut - 1'b1;
      3:       return cut_cfg.low_cut;
      4:       return cut_cfg.low_cut + 1'b1;
      5:       return cut_cfg.high_cut - 1'b1;
      6:       return cut_cfg.high_cut;
      7:       return cut_cfg.high_cut + 1'b1;
      default: return LEVEL_BITS'($urandom);
    endcase
  endfunction

  function automatic int unsigned group_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return $urandom_range(MAX_BINS - 4, MAX_BINS + 26);   // runs past the cap
    if (r < 30) return 1;
    return $urandom_range(2, 10);
  endfunction

  task automatic queue_group(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) put_bin(pick_level(), i == n - 1);
  endtask

  task automatic randomise_regs(input int unsigned phase);
    band_shape_e            shape;
    logic [CUT_W-1:0]       lo;
    logic [CUT_W-1:0]       hi;
    if (phase < 3) shape = band_shape_e'(phase);
    else if ($urandom_range(0, 1) == 0) shape = BAND_WIDE;
    else shape = band_shape_e'($urandom_range(0, 4));
    case (shape)
      BAND_FULL: begin
        lo = '0;
        hi = '1;
      end
      BAND_EMPTY: begin
        lo = CUT_W'($urandom);
        hi = lo;
      end
      BAND_INVERTED: begin
        hi = CUT_W'($urandom_range(0, 65534));
        lo = CUT_W'($urandom_range(hi + 1, 65535));
      end
      BAND_NARROW: begin
        lo = CUT_W'($urandom_range(0, 65000));
        hi = CUT_W'(lo + $urandom_range(1, 16));
      end
      default: begin
        lo = CUT_W'($urandom_range(0, 40000));
        hi = CUT_W'(lo + $urandom_range(1, 65535 - lo));
      end
    endcase
    write_reg(REG_LOW_CUT, lo);
    write_reg(REG_HIGH_CUT, hi);
    write_reg(REG_FROM_RED, colour_word());
    write_reg(REG_FROM_GREEN, colour_word());
    write_reg(REG_FROM_BLUE, colour_word());
    write_reg(REG_TO_RED, colour_word());
    write_reg(REG_TO_GREEN, colour_word());
    write_reg(REG_TO_BLUE, colour_word());
    if ($urandom_range(0, 2) == 0) write_reg(REG_UNMAPPED, CFG_DATA_W'($urandom));
  endtask

  // --------------------------------------------------------------------------
  // Run
  // --------------------------------------------------------------------------
  initial begin : run
    int unsigned n;
    int unsigned phase_items;

    clk           = 1'b0;
    rst_n         = 1'b0;
    in_bus.valid  = 1'b0;
    in_bus.level  = '0;
    in_bus.last   = 1'b0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.addr  = '0;
    cfg_bus.data  = '0;

    // register defaults as loaded by reset
    cut_cfg.low_cut  = 16'd0;
    cut_cfg.high_cut = 16'd255;
    cut_cfg.from_col = '0;
    cut_cfg.to_col   = '1;
    group_sum  = 0;
    group_bins = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: silent bin, saturated bin, a short mixed group
    put_bin(16'd0, 1'b1);
    put_bin(16'hFFFF, 1'b1);
    put_bin(16'd128, 1'b0);
    put_bin(16'd255, 1'b0);
    put_bin(16'd256, 1'b1);
    drain();

    // band 100..1000: either side of and on both cut points
    write_reg(REG_LOW_CUT, 16'd100);
    write_reg(REG_HIGH_CUT, 16'd1000);
    write_reg(REG_FROM_RED, 16'd10);
    write_reg(REG_FROM_GREEN, 16'd20);
    write_reg(REG_FROM_BLUE, 16'd30);
    write_reg(REG_TO_RED, 16'd200);
    write_reg(REG_TO_GREEN, 16'd100);
    write_reg(REG_TO_BLUE, 16'd250);
    put_bin(16'd99, 1'b0);
    put_bin(16'd100, 1'b0);
    put_bin(16'd101, 1'b1);
    put_bin(16'd999, 1'b0);
    put_bin(16'd1000, 1'b0);
    put_bin(16'd1001, 1'b1);
    put_bin(16'd550, 1'b1);
    drain();

    // empty band: zero divisor, from colour comes out; unmapped write ignored
    write_reg(REG_LOW_CUT, 16'd500);
    write_reg(REG_HIGH_CUT, 16'd500);
    write_reg(REG_FROM_RED, 16'hFFFF);
    write_reg(REG_FROM_GREEN, 16'h0000);
    write_reg(REG_FROM_BLUE, 16'd128);
    write_reg(REG_TO_RED, 16'h0000);
    write_reg(REG_TO_GREEN, 16'hFFFF);
    write_reg(REG_TO_BLUE, 16'd64);
    write_reg(REG_UNMAPPED, 16'hFFFF);
    put_bin(16'd600, 1'b0);
    put_bin(16'hFFFF, 1'b1);
    drain();

    // inverted band, also no span
    write_reg(REG_LOW_CUT, 16'hFFFF);
    write_reg(REG_HIGH_CUT, 16'h0000);
    put_bin(16'hFFFF, 1'b1);
    drain();

    // widest band with black to white
    write_reg(REG_LOW_CUT, 16'h0000);
    write_reg(REG_HIGH_CUT, 16'hFFFF);
    write_reg(REG_FROM_RED, 16'h0000);
    write_reg(REG_FROM_GREEN, 16'h0000);
    write_reg(REG_FROM_BLUE, 16'h0000);
    write_reg(REG_TO_RED, 16'h00FF);
    write_reg(REG_TO_GREEN, 16'h00FF);
    write_reg(REG_TO_BLUE, 16'h00FF);
    put_bin(16'hFFFF, 1'b1);
    put_bin(16'd32768, 1'b1);
    put_bin(16'd1, 1'b0);
    put_bin(16'd0, 1'b1);
    drain();

    // random phases; one of them runs short groups into a long receiver hold
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      randomise_regs(p);
      if (p == PRESSURE_PHASE) hold_asks++;
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
        n = (p == PRESSURE_PHASE) ? $urandom_range(1, 2) : group_len();
        queue_group(n);
        phase_items += n;
      end
      drain();
    end

    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin : watchdog
    #(CLK_PERIOD * CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/slc_pkg.sv
hw/rtl/slc_if.sv
hw/rtl/slc_queue.sv
hw/rtl/slc_front.sv
hw/rtl/slc_back.sv
hw/rtl/spectrum_level_to_color_core.sv
tb/tb_spectrum_level_to_color_core.sv
